// ===== rtl/bffa_pkg.sv =====
// ----------------------------------------------------------------------------
// bffa_pkg
// Shared types, constants and helpers of the first-fit bitmap allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bffa_pkg;

    // Bitmap geometry: bytes are grouped into RAM rows of ROW_BYTES each.
    localparam int BITMAP_BYTES = 512;
    localparam int ROW_BYTES    = 8;
    localparam int ROW_BITS     = ROW_BYTES * 8;
    localparam int NUM_ROWS     = BITMAP_BYTES / ROW_BYTES;
    localparam int ROW_AW       = $clog2(NUM_ROWS);
    localparam int BIT_AW       = $clog2(ROW_BITS);
    localparam int BYTE_AW      = $clog2(ROW_BYTES);
    localparam int ROWCNT_W     = $clog2(NUM_ROWS + 1);

    // Field and register widths
    localparam int IDX_W    = 12;
    localparam int STAT_W   = 2;
    localparam int BYTES_W  = 10;
    localparam int LIMIT_W  = 13;
    localparam int CFG_AW   = 1;

    // Command codes
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    // Register indexes
    localparam logic [CFG_AW-1:0] REG_BYTES_IN_USE = 1'b0;
    localparam logic [CFG_AW-1:0] REG_ENTRY_LIMIT  = 1'b1;

    localparam logic [BYTES_W-1:0] BYTES_RESET = BYTES_W'(512);
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(4096);
    localparam logic [BYTES_W-1:0] BYTES_MAX   = BYTES_W'(BITMAP_BYTES);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FREE_WR,
        S_DONE
    } t_state;

    // Result of searching one RAM row for a clear bit
    typedef struct packed {
        logic              found;
        logic [BIT_AW-1:0] bit_off;
    } t_search;

    // Lowest clear bit of a byte (bit 0 stands for the lowest entry)
    function automatic logic [2:0] first_zero8(input logic [7:0] v);
        logic [2:0] pos;
        pos = 3'd0;
        for (int k = 7; k >= 0; k--) begin
            if (!v[k]) begin
                pos = 3'(k);
            end
        end
        return pos;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/bitmap_first_free_allocator_unit.sv =====
// Free reads the row, writes it back with the bit cleared and then loads its
// result; an out-of-range free or an allocate over an empty span loads it at once;
// allocate scans rows from row 0 until one holds a clear bit in the span, or
// reports full after its last row, or out of range for a bit at or past the limit.
// Throughput: one request at a time, the next accepted in the cycle after the
// result is loaded; the scan reads one 64-entry RAM row per cycle.
// ----------------------------------------------------------------------------
// bitmap_first_free_allocator_unit
// First-fit allocator over a bitmap held in a row RAM, with free by index.
// Reset clears the control state and marks every bitmap row free at once.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_first_free_allocator_unit (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire logic                             i_cmd,
    input  wire logic [bffa_pkg::IDX_W-1:0]       i_entry_index,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output logic      [bffa_pkg::STAT_W-1:0]      o_status,
    output logic      [bffa_pkg::IDX_W-1:0]       o_granted_index,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [bffa_pkg::CFG_AW-1:0]      i_cfg_index,
    input  wire logic [bffa_pkg::LIMIT_W-1:0]     i_cfg_data
);
    import bffa_pkg::*;

    t_state              r_state, n_state;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic [ROWCNT_W-1:0] r_scan_row, n_scan_row;
    logic                r_rd_pend, n_rd_pend;
    logic [ROW_AW-1:0]   r_rd_row, n_rd_row;
    logic [STAT_W-1:0]   r_res_status, n_res_status;
    logic [IDX_W-1:0]    r_res_index, n_res_index;
    logic                r_out_valid, n_out_valid;
    logic [STAT_W-1:0]   r_out_status, n_out_status;
    logic [IDX_W-1:0]    r_out_index, n_out_index;
    logic [BYTES_W-1:0]  r_bytes_in_use;
    logic [LIMIT_W-1:0]  r_entry_limit;

    logic [BYTES_W-1:0]  w_span;
    logic [ROWCNT_W-1:0] w_rows;
    logic                w_out_free;
    logic [IDX_W-1:0]    w_grant;
    t_search             w_search;

    logic                mem_we;
    logic [ROW_AW-1:0]   mem_waddr;
    logic [ROW_BITS-1:0] mem_wdata;
    logic                mem_re;
    logic [ROW_AW-1:0]   mem_raddr;
    logic [ROW_BITS-1:0] mem_rdata;

    bffa_row_ram u_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    bffa_row_search u_search (
        .i_row_data (mem_rdata),
        .i_row      (r_rd_row),
        .i_span     (w_span),
        .o_result   (w_search)
    );

    // Scan span saturates at the bitmap size; rows round up
    assign w_span  = (r_bytes_in_use > BYTES_MAX) ? BYTES_MAX : r_bytes_in_use;
    assign w_rows  = ROWCNT_W'((BYTES_W + 1)'(w_span) + (BYTES_W + 1)'(ROW_BYTES - 1)
                     >> BYTE_AW);
    assign w_grant = IDX_W'({r_rd_row, w_search.bit_off});

    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_granted_index = r_out_index;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_in_use <= BYTES_RESET;
            r_entry_limit  <= LIMIT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_BYTES_IN_USE: r_bytes_in_use <= i_cfg_data[BYTES_W-1:0];
                REG_ENTRY_LIMIT:  r_entry_limit  <= i_cfg_data;
                default:          r_entry_limit  <= r_entry_limit;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rd_pend   <= n_rd_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_scan_row   <= n_scan_row;
        r_rd_row     <= n_rd_row;
        r_res_status <= n_res_status;
        r_res_index  <= n_res_index;
        r_out_status <= n_out_status;
        r_out_index  <= n_out_index;
    end

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_scan_row   = r_scan_row;
        n_rd_pend    = r_rd_pend;
        n_rd_row     = r_rd_row;
        n_res_status = r_res_status;
        n_res_index  = r_res_index;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_status = r_out_status;
        n_out_index  = r_out_index;
        mem_re       = 1'b0;
        mem_raddr    = r_scan_row[ROW_AW-1:0];
        mem_we       = 1'b0;
        mem_waddr    = r_rd_row;
        mem_wdata    = mem_rdata;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_idx = i_entry_index;
                    if (i_cmd == CMD_ALLOC) begin
                        if (w_rows == '0) begin
                            n_res_status = ST_FULL;
                            n_res_index  = '0;
                            n_state      = S_DONE;
                        end else begin
                            n_scan_row = '0;
                            n_rd_pend  = 1'b0;
                            n_state    = S_SCAN;
                        end
                    end else if (LIMIT_W'(i_entry_index) >= r_entry_limit) begin
                        n_res_status = ST_RANGE;
                        n_res_index  = '0;
                        n_state      = S_DONE;
                    end else begin
                        // fetch the row for read-modify-write
                        mem_re    = 1'b1;
                        mem_raddr = i_entry_index[IDX_W-1 -: ROW_AW];
                        n_rd_row  = i_entry_index[IDX_W-1 -: ROW_AW];
                        n_state   = S_FREE_WR;
                    end
                end
            end
            S_SCAN: begin
                // issue the next row read while the previous one is checked
                if (r_scan_row < w_rows) begin
                    mem_re     = 1'b1;
                    n_scan_row = r_scan_row + ROWCNT_W'(1);
                    n_rd_pend  = 1'b1;
                    n_rd_row   = r_scan_row[ROW_AW-1:0];
                end else begin
                    n_rd_pend = 1'b0;
                end
                if (r_rd_pend) begin
                    if (w_search.found) begin
                        if (LIMIT_W'(w_grant) >= r_entry_limit) begin
                            n_res_status = ST_RANGE;
                            n_res_index  = '0;
                        end else begin
                            mem_we       = 1'b1;
                            mem_wdata    = mem_rdata | (ROW_BITS'(1) << w_search.bit_off);
                            n_res_status = ST_OK;
                            n_res_index  = w_grant;
                        end
                        n_rd_pend = 1'b0;
                        n_state   = S_DONE;
                    end else if (ROWCNT_W'(r_rd_row) == w_rows - ROWCNT_W'(1)) begin
                        n_res_status = ST_FULL;
                        n_res_index  = '0;
                        n_rd_pend    = 1'b0;
                        n_state      = S_DONE;
                    end
                end
            end
            S_FREE_WR: begin
                mem_we       = 1'b1;
                mem_wdata    = mem_rdata & ~(ROW_BITS'(1) << r_idx[BIT_AW-1:0]);
                n_res_status = ST_OK;
                n_res_index  = '0;
                n_state      = S_DONE;
            end
            S_DONE: begin
                // hold the result until the output register frees up
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_index  = r_res_index;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/bffa_row_ram.sv =====
// ----------------------------------------------------------------------------
// bffa_row_ram
// Bitmap storage: one row of entry bits per address, registered read,
// per-row valid bits so that rows never written read as all free.
// ----------------------------------------------------------------------------
`default_nettype none

module bffa_row_ram (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_we,
    input  wire logic [bffa_pkg::ROW_AW-1:0]   i_waddr,
    input  wire logic [bffa_pkg::ROW_BITS-1:0] i_wdata,
    input  wire logic                          i_re,
    input  wire logic [bffa_pkg::ROW_AW-1:0]   i_raddr,
    output logic      [bffa_pkg::ROW_BITS-1:0] o_rdata
);
    import bffa_pkg::*;

    logic [ROW_BITS-1:0] r_mem [NUM_ROWS];
    logic [NUM_ROWS-1:0] r_row_vld;
    logic [ROW_BITS-1:0] r_rd_word;
    logic                r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rd_word <= r_mem[i_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            if (i_re) begin
                r_rd_vld <= r_row_vld[i_raddr];
            end
            if (i_we) begin
                r_row_vld[i_waddr] <= 1'b1;
            end
        end
    end

    assign o_rdata = r_rd_vld ? r_rd_word : '0;

endmodule

`default_nettype wire

// ===== rtl/bffa_row_search.sv =====
// ----------------------------------------------------------------------------
// bffa_row_search
// Finds the lowest clear entry bit of one bitmap row, skipping bytes that
// lie beyond the scanned span.
// ----------------------------------------------------------------------------
`default_nettype none

module bffa_row_search (
    input  wire logic [bffa_pkg::ROW_BITS-1:0] i_row_data,
    input  wire logic [bffa_pkg::ROW_AW-1:0]   i_row,
    input  wire logic [bffa_pkg::BYTES_W-1:0]  i_span,
    output bffa_pkg::t_search                  o_result
);
    import bffa_pkg::*;

    logic [ROW_BYTES-1:0] w_byte_ok;
    logic [BYTE_AW-1:0]   w_byte_sel;
    logic [7:0]           w_sel_byte;

    always_comb begin
        for (int j = 0; j < ROW_BYTES; j++) begin
            w_byte_ok[j] = (BYTES_W'({i_row, BYTE_AW'(j)}) < i_span)
                        && (i_row_data[j*8 +: 8] != 8'hFF);
        end
    end

    // Lowest byte with room wins
    always_comb begin
        w_byte_sel = '0;
        for (int j = ROW_BYTES - 1; j >= 0; j--) begin
            if (w_byte_ok[j]) begin
                w_byte_sel = BYTE_AW'(j);
            end
        end
    end

    assign w_sel_byte       = i_row_data[w_byte_sel*8 +: 8];
    assign o_result.found   = |w_byte_ok;
    assign o_result.bit_off = {w_byte_sel, first_zero8(w_sel_byte)};

endmodule

`default_nettype wire

// ===== rtl/bffa_checker.sv =====
// ----------------------------------------------------------------------------
// bffa_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bffa_checker (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         i_in_valid,
    input wire logic                         o_in_stall,
    input wire logic                         o_out_valid,
    input wire logic                         i_out_stall,
    input wire logic [bffa_pkg::STAT_W-1:0]  o_status,
    input wire logic [bffa_pkg::IDX_W-1:0]   o_granted_index
);
    import bffa_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status)
            && $stable(o_granted_index))
        else $error("stalled result changed");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == ST_OK || o_status == ST_RANGE
            || o_status == ST_FULL))
        else $error("bad status code");

    a_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_OK |-> o_granted_index == '0)
        else $error("index not zero on error");

    a_ready_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_in_stall)
        else $error("request port stalled after reset");

endmodule

bind bitmap_first_free_allocator_unit bffa_checker u_bffa_checker (.*);

`default_nettype wire

// ===== test/bitmap_first_free_allocator_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_first_free_allocator_unit_test
// Self-checking bench for the first-fit allocator. A queue of allocate and
// free requests feeds a clocked driver. A shadow bitmap predicts the status
// and grant of every accepted request, and a clocked monitor compares each
// result in order. The run changes bytes_in_use and entry_limit between
// phases, including zero, saturating and maximum values, and it varies the
// idle and stall patterns on both sides.
// ----------------------------------------------------------------------------

module bitmap_first_free_allocator_unit_test;
    import bffa_pkg::*;

    localparam int CYCLE_LIMIT  = 1_500_000;
    localparam int DRAIN_CYCLES = 100;
    localparam int HOLD_CYCLES  = 400;
    localparam int RAND_PHASES  = 8;
    localparam int PHASE_ITEMS  = 135;

    typedef struct packed {
        logic             cmd;
        logic [IDX_W-1:0] index;
    } alloc_req_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [IDX_W-1:0]  granted;
    } alloc_resp_t;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    logic                i_cmd = CMD_ALLOC;
    logic [IDX_W-1:0]    i_entry_index = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic [STAT_W-1:0]   o_status;
    logic [IDX_W-1:0]    o_granted_index;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [CFG_AW-1:0]   i_cfg_index;
    logic [LIMIT_W-1:0]  i_cfg_data;

    bitmap_first_free_allocator_unit DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_cmd           (i_cmd),
        .i_entry_index   (i_entry_index),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_granted_index (o_granted_index),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Shadow copy of the allocator state
    logic [7:0]         usage_map [BITMAP_BYTES];
    logic [BYTES_W-1:0] bytes_cfg;
    logic [LIMIT_W-1:0] limit_cfg;

    alloc_req_t  pending_q [$];
    alloc_resp_t expected_q [$];

    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;
    logic hold_armed = 1'b0;
    logic hold_taken = 1'b0;
    int   hold_left  = 0;

    int error_count = 0;
    int cycle_count = 0;
    int n_alloc = 0, n_free = 0;
    int n_ok = 0, n_range = 0, n_full = 0;
    int n_settings = 0;

    function automatic alloc_resp_t predict_request(input alloc_req_t req);
        alloc_resp_t r;
        int span;
        int k;
        logic [7:0] v;
        logic [LIMIT_W-1:0] idx;
        r.status  = ST_FULL;
        r.granted = '0;
        if (req.cmd == CMD_ALLOC) begin
            span = (bytes_cfg > BYTES_MAX) ? BITMAP_BYTES : int'(bytes_cfg);
            for (int b = 0; b < span; b++) begin
                if (usage_map[b] != 8'hFF) begin
                    v = usage_map[b];
                    k = 0;
                    while (k < 8 && v[7-k])
                        k++;
                    idx = LIMIT_W'(b * 8 + k);
                    if (idx >= limit_cfg) begin
                        r.status = ST_RANGE;
                    end else begin
                        usage_map[b][7-k] = 1'b1;
                        r.status  = ST_OK;
                        r.granted = idx[IDX_W-1:0];
                    end
                    break;
                end
            end
        end else begin
            if ({1'b0, req.index} >= limit_cfg) begin
                r.status = ST_RANGE;
            end else begin
                usage_map[req.index[IDX_W-1:3]][3'd7 - req.index[2:0]] = 1'b0;
                r.status = ST_OK;
            end
        end
        return r;
    endfunction

    // Request driver: hold a stalled request, otherwise offer the next one
    always @(posedge i_clk) begin
        alloc_req_t acc;
        alloc_req_t nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                acc.cmd   = i_cmd;
                acc.index = i_entry_index;
                expected_q.push_back(predict_request(acc));
                if (acc.cmd == CMD_ALLOC) n_alloc++;
                else n_free++;
            end
            if (i_in_valid && o_in_stall) begin
                // hold payload
            end else if (pending_q.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
                nxt = pending_q.pop_front();
                i_in_valid    <= 1'b1;
                i_cmd         <= nxt.cmd;
                i_entry_index <= nxt.index;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver stall, with one long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else if (hold_armed && !hold_taken) begin
            i_out_stall <= 1'b1;
            hold_left   <= HOLD_CYCLES;
            hold_taken  <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Result monitor
    always @(posedge i_clk) begin
        alloc_resp_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_q.size() == 0) begin
                error_count++;
                if (error_count <= 10)
                    $display("unexpected result: status %0d index %0d",
                             o_status, o_granted_index);
            end else begin
                want = expected_q.pop_front();
                case (want.status)
                    ST_OK:    n_ok++;
                    ST_RANGE: n_range++;
                    default:  n_full++;
                endcase
                if (o_status !== want.status || o_granted_index !== want.granted) begin
                    error_count++;
                    if (error_count <= 10)
                        $display("mismatch: expected status %0d index %0d, got status %0d index %0d",
                                 want.status, want.granted, o_status, o_granted_index);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_q.size());
            $display("FAILURE");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_AW-1:0] index, input int data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= LIMIT_W'(data);
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (index == REG_BYTES_IN_USE) bytes_cfg = BYTES_W'(data);
        else limit_cfg = LIMIT_W'(data);
        n_settings++;
    endtask

    task automatic push_req(input logic cmd, input int index);
        alloc_req_t r;
        r.cmd   = cmd;
        r.index = IDX_W'(index);
        pending_q.push_back(r);
    endtask

    // Wait until every request is accepted and every result has come back
    task automatic drain();
        @(posedge i_clk);
        while (pending_q.size() > 0 || expected_q.size() > 0 || i_in_valid)
            @(posedge i_clk);
    endtask

    initial begin
        int bytes_val;
        int limit_val;
        int span;
        int top;
        int r;
        int alloc_w;
        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_BYTES_IN_USE;
        i_cfg_data  = '0;
        for (int b = 0; b < BITMAP_BYTES; b++)
            usage_map[b] = 8'h00;
        bytes_cfg = BYTES_RESET;
        limit_cfg = LIMIT_RESET;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // One byte in use: fill it, overflow, free twice, refill, edge indices
        write_reg(REG_BYTES_IN_USE, 1);
        write_reg(REG_ENTRY_LIMIT, 4096);
        repeat (9) push_req(CMD_ALLOC, 0);
        push_req(CMD_FREE, 3);
        push_req(CMD_FREE, 3);
        push_req(CMD_ALLOC, 4095);
        push_req(CMD_FREE, 4095);
        push_req(CMD_FREE, 0);
        drain();

        // Nothing scanned, nothing in range
        write_reg(REG_BYTES_IN_USE, 0);
        write_reg(REG_ENTRY_LIMIT, 0);
        push_req(CMD_ALLOC, 0);
        push_req(CMD_FREE, 0);
        push_req(CMD_FREE, 4095);
        drain();

        // Saturating scan span with a tiny limit: grant beyond limit is rejected
        write_reg(REG_BYTES_IN_USE, 1023);
        write_reg(REG_ENTRY_LIMIT, 4);
        push_req(CMD_ALLOC, 0);
        push_req(CMD_ALLOC, 0);
        push_req(CMD_FREE, 4);
        push_req(CMD_FREE, 3);
        push_req(CMD_ALLOC, 0);
        drain();

        write_reg(REG_BYTES_IN_USE, 512);
        write_reg(REG_ENTRY_LIMIT, 8191);
        push_req(CMD_FREE, 4095);
        push_req(CMD_ALLOC, 0);
        drain();

        for (int p = 0; p < RAND_PHASES; p++) begin
            case (p)
                0: begin bytes_val = 512; limit_val = 4096; end
                1: begin bytes_val = $urandom_range(4, 1); limit_val = 4096; end
                2: begin
                    bytes_val = $urandom_range(64, 1);
                    limit_val = $urandom_range(bytes_val * 8, 1);
                end
                3: begin
                    // junk in the upper data bits must be dropped
                    bytes_val = $urandom_range(1023) | ($urandom_range(7) << BYTES_W);
                    limit_val = $urandom_range(8191);
                end
                4: begin bytes_val = 1; limit_val = 8191; end
                5: begin
                    bytes_val = $urandom_range(40, 5);
                    limit_val = $urandom_range(4096, 1);
                end
                6: begin bytes_val = 512; limit_val = $urandom_range(600, 1); end
                default: begin
                    bytes_val = $urandom_range(16, 1);
                    limit_val = $urandom_range(bytes_val * 8 + 8);
                end
            endcase
            write_reg(REG_BYTES_IN_USE, bytes_val);
            write_reg(REG_ENTRY_LIMIT, limit_val);

            case (p % 4)
                0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin sender_idle_pct = 76; recv_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  recv_stall_pct = 76; end
                default: begin sender_idle_pct = 21; recv_stall_pct = 21; end
            endcase
            if (p == 0) hold_armed = 1'b1;

            span    = (bytes_cfg > BYTES_MAX) ? BITMAP_BYTES : int'(bytes_cfg);
            top     = (span * 8 + 7 > 4095) ? 4095 : span * 8 + 7;
            alloc_w = (p == 0) ? 80 : 55;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                r = $urandom_range(99);
                if (r < alloc_w) push_req(CMD_ALLOC, $urandom_range(4095));
                else if (r < 92) push_req(CMD_FREE, $urandom_range(top));
                else push_req(CMD_FREE, $urandom_range(4095));
            end
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Ran %0d allocate and %0d free requests over %0d register writes",
                 n_alloc, n_free, n_settings);
        $display("Outcomes: %0d ok, %0d out of range, %0d bitmap full; %0d errors",
                 n_ok, n_range, n_full, error_count);
        if (error_count == 0 && expected_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/bffa_pkg.sv
rtl/bffa_row_ram.sv
rtl/bffa_row_search.sv
rtl/bitmap_first_free_allocator_unit.sv
rtl/bffa_checker.sv
test/bitmap_first_free_allocator_unit_test.sv
